FILE: design/slab_pkg.sv
package slab_pkg;

    localparam int MAX_SAMPLES_DEF = 64;

    localparam int COORD_W = 32;
    localparam int STEP_W  = 31;
    localparam int PLIM_W  = 16;
    localparam int IDX_W   = 6;
    localparam int MAG_W   = 32;
    localparam int H_W     = 33;
    localparam int PROD_W  = 64;
    localparam int QC_W    = 61;
    localparam int BASE_W  = 62;
    localparam int PT_W    = 63;
    localparam int AHI_W   = 47;
    localparam int HI_W    = 53;
    localparam int LO_W    = 22;
    localparam int FRAC_W  = 16;

    localparam logic [STEP_W-1:0] STEP_RST = 31'd65536;
    localparam logic [PLIM_W-1:0] PLIM_RST = 16'd1;
    localparam logic [PROD_W-1:0] Q_CLAMP  = 64'h1000_0000_0000_0000;

    typedef enum logic {
        CFG_STEP = 1'b0,
        CFG_PLIM = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic             start;
        logic [H_W-1:0]   a;
        logic [MAG_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] num;
        logic [PROD_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quo;
        logic              rem_nz;
    } t_div_res;

    function automatic logic [COORD_W-1:0] sat32(input logic signed [PT_W-1:0] v);
        logic signed [PT_W-1:0] hi;
        logic signed [PT_W-1:0] lo;
        hi = PT_W'(32'sh7FFF_FFFF);
        lo = PT_W'(-33'sd2147483648);
        if (v > hi) begin
            return 32'h7FFF_FFFF;
        end else if (v < lo) begin
            return 32'h8000_0000;
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

FILE: design/slab_mul.sv
module slab_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  slab_pkg::t_mul_req            i_req,
    output logic                          o_done,
    output logic [slab_pkg::PROD_W-1:0]   o_prod
);
    import slab_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);

    logic [PROD_W-1:0] r_a;
    logic [PROD_W-1:0] r_acc;
    logic [MAG_W-1:0]  r_b;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    // shift-add, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= PROD_W'(i_req.a);
                r_b    <= i_req.b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a   <= r_a << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

FILE: design/slab_div.sv
module slab_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  slab_pkg::t_div_req  i_req,
    output slab_pkg::t_div_res  o_res
);
    import slab_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    logic [PROD_W-1:0] r_rem;
    logic [PROD_W-1:0] r_q;
    logic [PROD_W-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [PROD_W:0]   trial;
    logic [PROD_W:0]   diff;
    logic              ge;

    // restoring division, one quotient bit per cycle
    assign trial = {r_rem, r_q[PROD_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= '0;
                r_q    <= i_req.num;
                r_den  <= i_req.den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
                r_q   <= {r_q[PROD_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(PROD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done   = r_done;
    assign o_res.quo    = r_q;
    assign o_res.rem_nz = |r_rem;

endmodule

FILE: design/axis_slab_sampler.sv
// axis_slab_sampler: samples a line between a floor plane and a ceiling plane.
// Input channel (i_in_valid / o_in_stall) carries one request: line origin,
// line direction and the two plane heights, all signed Q16.16. Output channel
// (o_out_valid / i_out_stall) returns the sample points of that request, one
// result per accepted cycle, with o_last on the final one. A near-parallel
// line or a zero sample count gives a single result with o_empty_res set.
// Config port (i_cfg_we, i_cfg_index, i_cfg_data): index 0 is the sample
// step, index 1 the parallel limit. Write only while the block is idle.
// The first point is computed by one shared bit-serial multiplier (ten
// products), one shared bit-serial divider (three quotients) and a 32-step
// square root. A near-parallel line goes from the check state straight to its
// empty result; a zero count reaches it after the count division.
// Points then leave at one per cycle while the receiver does not stall; a new
// request is taken once the last result sits in the output register.
// A stalled receiver holds the output register and the emission.
// Reset: synchronous active low; restores step 1.0 and parallel limit 1,
// drops any request in flight and clears the output valid.
module axis_slab_sampler #(
    parameter int MAX_SAMPLES = slab_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_index,
    input  logic [slab_pkg::STEP_W-1:0]          i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [slab_pkg::COORD_W-1:0]  i_origin_x,
    input  logic signed [slab_pkg::COORD_W-1:0]  i_origin_y,
    input  logic signed [slab_pkg::COORD_W-1:0]  i_origin_z,
    input  logic signed [slab_pkg::COORD_W-1:0]  i_dir_x,
    input  logic signed [slab_pkg::COORD_W-1:0]  i_dir_y,
    input  logic signed [slab_pkg::COORD_W-1:0]  i_dir_z,
    input  logic signed [slab_pkg::COORD_W-1:0]  i_floor_z,
    input  logic signed [slab_pkg::COORD_W-1:0]  i_ceiling_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [slab_pkg::COORD_W-1:0]  o_point_x,
    output logic signed [slab_pkg::COORD_W-1:0]  o_point_y,
    output logic signed [slab_pkg::COORD_W-1:0]  o_point_z,
    output logic [slab_pkg::IDX_W-1:0]           o_sample_index,
    output logic                                 o_empty_res,
    output logic                                 o_clipped,
    output logic                                 o_last
);
    import slab_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SQ_W  = $clog2(MAG_W);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_MBX, S_DBX, S_MBY, S_DBY, S_SQX, S_SQY, S_SQZ,
        S_SQRT, S_NORM, S_MNUM, S_MDEN, S_DCNT, S_MAX, S_MAY, S_MAZ,
        S_EMIT, S_EMPTY
    } t_state;

    t_state r_state;

    // configuration
    logic [STEP_W-1:0] r_step;
    logic [PLIM_W-1:0] r_plim;
    logic [STEP_W-1:0] step_eff;

    // request registers
    logic signed [COORD_W-1:0] r_org_x;
    logic signed [COORD_W-1:0] r_org_y;
    logic signed [COORD_W-1:0] r_floor;
    logic [MAG_W-1:0]          r_dabs [3];
    logic [2:0]                r_dneg;
    logic [H_W-1:0]            r_ah;
    logic                      r_hneg;
    logic [H_W-1:0]            r_dh;

    // shared units
    t_mul_req          r_mreq;
    t_div_req          r_dreq;
    logic              mul_done;
    logic [PROD_W-1:0] mul_prod;
    t_div_res          div_res;

    // square root
    logic [PROD_W-1:0] r_ssum;
    logic [PROD_W-1:0] r_sx;
    logic [PROD_W-1:0] r_sr;
    logic [PROD_W-1:0] r_sbit;
    logic [SQ_W-1:0]   r_scnt;
    logic [PROD_W-1:0] sq_trial;

    logic [PROD_W-1:0] r_num;

    // emission
    logic signed [BASE_W-1:0] r_base [3];
    logic [AHI_W-1:0]         r_ahi  [3];
    logic [FRAC_W-1:0]        r_alo  [3];
    logic [HI_W-1:0]          r_hacc [3];
    logic [LO_W-1:0]          r_lacc [3];
    logic [CNT_W-1:0]         r_i;
    logic [CNT_W-1:0]         r_count;
    logic                     r_clip;
    logic                     emit_last;

    // output register
    logic                      r_out_valid;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic signed [COORD_W-1:0] r_pz;
    logic [IDX_W-1:0]          r_idx;
    logic                      r_empty;
    logic                      r_oclip;
    logic                      r_last;

    // request decode
    logic signed [H_W-1:0] in_h;
    logic signed [H_W-1:0] in_dh;
    logic                  in_accept;

    // floor hit
    logic [QC_W-1:0]          q_clamped;
    logic                     base_sel_y;
    logic                     base_neg;
    logic signed [BASE_W-1:0] base_org;
    logic signed [BASE_W-1:0] base_q;
    logic signed [BASE_W-1:0] base_new;

    // count
    logic                     cnt_zero;
    logic                     cnt_clip;

    logic [COORD_W-1:0] pt [3];
    logic               out_free;

    slab_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mreq),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    slab_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_dreq),
        .o_res   (div_res)
    );

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign in_h      = H_W'(i_floor_z) - H_W'(i_origin_z);
    assign in_dh     = H_W'(i_ceiling_z) - H_W'(i_floor_z);
    assign step_eff  = (r_step == '0) ? STEP_W'(1) : r_step;
    assign out_free  = !r_out_valid || !i_out_stall;

    // floor hit of x or y: origin plus signed, clamped quotient
    assign q_clamped  = (div_res.quo > Q_CLAMP) ? Q_CLAMP[QC_W-1:0] : div_res.quo[QC_W-1:0];
    assign base_sel_y = (r_state == S_DBY);
    assign base_neg   = r_hneg ^ (base_sel_y ? r_dneg[1] : r_dneg[0]) ^ r_dneg[2];
    assign base_org   = BASE_W'(base_sel_y ? r_org_y : r_org_x);
    assign base_q     = signed'({1'b0, q_clamped});
    assign base_new   = base_neg ? (base_org - base_q) : (base_org + base_q);

    assign sq_trial = r_sr + r_sbit;

    assign cnt_zero = (div_res.quo == '0) && !div_res.rem_nz;
    assign cnt_clip = (div_res.quo > PROD_W'(MAX_SAMPLES))
                   || ((div_res.quo == PROD_W'(MAX_SAMPLES)) && div_res.rem_nz);

    assign emit_last = (r_i + CNT_W'(1)) == r_count;

    // point of the current index: floor hit plus upward-signed offset
    always_comb begin
        logic [HI_W-1:0]        off;
        logic signed [PT_W-1:0] offs;
        logic signed [PT_W-1:0] sum;
        logic                   neg;
        for (int c = 0; c < 3; c++) begin
            off   = r_hacc[c] + HI_W'(r_lacc[c][LO_W-1:FRAC_W]);
            offs  = signed'(PT_W'(off));
            neg   = r_dneg[c] ^ r_dneg[2];
            sum   = PT_W'(r_base[c]) + (neg ? -offs : offs);
            pt[c] = sat32(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RST;
            r_plim <= PLIM_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_STEP: r_step <= i_cfg_data;
                CFG_PLIM: r_plim <= i_cfg_data[PLIM_W-1:0];
                default:  r_step <= r_step;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_mreq.start <= 1'b0;
            r_dreq.start <= 1'b0;
        end else begin
            r_mreq.start <= 1'b0;
            r_dreq.start <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_org_x   <= i_origin_x;
                        r_org_y   <= i_origin_y;
                        r_floor   <= i_floor_z;
                        r_dneg    <= {i_dir_z[COORD_W-1], i_dir_y[COORD_W-1],
                                      i_dir_x[COORD_W-1]};
                        r_dabs[0] <= i_dir_x[COORD_W-1] ? MAG_W'(-i_dir_x) : MAG_W'(i_dir_x);
                        r_dabs[1] <= i_dir_y[COORD_W-1] ? MAG_W'(-i_dir_y) : MAG_W'(i_dir_y);
                        r_dabs[2] <= i_dir_z[COORD_W-1] ? MAG_W'(-i_dir_z) : MAG_W'(i_dir_z);
                        r_hneg    <= in_h[H_W-1];
                        r_ah      <= in_h[H_W-1] ? H_W'(-in_h) : H_W'(in_h);
                        r_dh      <= in_dh[H_W-1] ? H_W'(-in_dh) : H_W'(in_dh);
                        r_state   <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    // z of the floor hit is the floor itself
                    r_base[2] <= BASE_W'(r_floor);
                    if ((r_dabs[2] == '0) || (r_dabs[2] < MAG_W'(r_plim))) begin
                        r_state <= S_EMPTY;
                    end else begin
                        r_mreq  <= '{start: 1'b1, a: r_ah, b: r_dabs[0]};
                        r_state <= S_MBX;
                    end
                end
                S_MBX: begin
                    if (mul_done) begin
                        r_dreq  <= '{start: 1'b1, num: mul_prod, den: PROD_W'(r_dabs[2])};
                        r_state <= S_DBX;
                    end
                end
                S_DBX: begin
                    if (div_res.done) begin
                        r_base[0] <= base_new;
                        r_mreq    <= '{start: 1'b1, a: r_ah, b: r_dabs[1]};
                        r_state   <= S_MBY;
                    end
                end
                S_MBY: begin
                    if (mul_done) begin
                        r_dreq  <= '{start: 1'b1, num: mul_prod, den: PROD_W'(r_dabs[2])};
                        r_state <= S_DBY;
                    end
                end
                S_DBY: begin
                    if (div_res.done) begin
                        r_base[1] <= base_new;
                        r_mreq    <= '{start: 1'b1, a: H_W'(r_dabs[0]), b: r_dabs[0]};
                        r_state   <= S_SQX;
                    end
                end
                S_SQX: begin
                    if (mul_done) begin
                        r_ssum  <= mul_prod;
                        r_mreq  <= '{start: 1'b1, a: H_W'(r_dabs[1]), b: r_dabs[1]};
                        r_state <= S_SQY;
                    end
                end
                S_SQY: begin
                    if (mul_done) begin
                        r_ssum  <= r_ssum + mul_prod;
                        r_mreq  <= '{start: 1'b1, a: H_W'(r_dabs[2]), b: r_dabs[2]};
                        r_state <= S_SQZ;
                    end
                end
                S_SQZ: begin
                    if (mul_done) begin
                        r_sx    <= r_ssum + mul_prod;
                        r_sr    <= '0;
                        r_sbit  <= PROD_W'(1) << (PROD_W - 2);
                        r_scnt  <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    // one root bit per cycle
                    if (r_sx >= sq_trial) begin
                        r_sx <= r_sx - sq_trial;
                        r_sr <= (r_sr >> 1) + r_sbit;
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                    r_scnt <= r_scnt + 1'b1;
                    if (r_scnt == SQ_W'(MAG_W - 1)) begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    r_mreq  <= '{start: 1'b1, a: r_dh, b: r_sr[MAG_W-1:0]};
                    r_state <= S_MNUM;
                end
                S_MNUM: begin
                    if (mul_done) begin
                        r_num   <= mul_prod;
                        r_mreq  <= '{start: 1'b1, a: H_W'(r_dabs[2]), b: MAG_W'(step_eff)};
                        r_state <= S_MDEN;
                    end
                end
                S_MDEN: begin
                    if (mul_done) begin
                        r_dreq  <= '{start: 1'b1, num: r_num, den: mul_prod};
                        r_state <= S_DCNT;
                    end
                end
                S_DCNT: begin
                    if (div_res.done) begin
                        if (cnt_zero) begin
                            r_state <= S_EMPTY;
                        end else begin
                            r_clip  <= cnt_clip;
                            r_count <= cnt_clip ? CNT_W'(MAX_SAMPLES)
                                     : CNT_W'(div_res.quo) + CNT_W'(div_res.rem_nz);
                            r_mreq  <= '{start: 1'b1, a: H_W'(r_dabs[0]), b: MAG_W'(step_eff)};
                            r_state <= S_MAX;
                        end
                    end
                end
                S_MAX: begin
                    if (mul_done) begin
                        r_ahi[0] <= mul_prod[FRAC_W +: AHI_W];
                        r_alo[0] <= mul_prod[FRAC_W-1:0];
                        r_mreq   <= '{start: 1'b1, a: H_W'(r_dabs[1]), b: MAG_W'(step_eff)};
                        r_state  <= S_MAY;
                    end
                end
                S_MAY: begin
                    if (mul_done) begin
                        r_ahi[1] <= mul_prod[FRAC_W +: AHI_W];
                        r_alo[1] <= mul_prod[FRAC_W-1:0];
                        r_mreq   <= '{start: 1'b1, a: H_W'(r_dabs[2]), b: MAG_W'(step_eff)};
                        r_state  <= S_MAZ;
                    end
                end
                S_MAZ: begin
                    if (mul_done) begin
                        r_ahi[2] <= mul_prod[FRAC_W +: AHI_W];
                        r_alo[2] <= mul_prod[FRAC_W-1:0];
                        for (int c = 0; c < 3; c++) begin
                            r_hacc[c] <= '0;
                            r_lacc[c] <= '0;
                        end
                        r_i     <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // one point per free output slot, then advance the offsets
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_px        <= pt[0];
                        r_py        <= pt[1];
                        r_pz        <= pt[2];
                        r_idx       <= IDX_W'(r_i);
                        r_empty     <= 1'b0;
                        r_oclip     <= r_clip;
                        r_last      <= emit_last;
                        for (int c = 0; c < 3; c++) begin
                            r_hacc[c] <= r_hacc[c] + HI_W'(r_ahi[c]);
                            r_lacc[c] <= r_lacc[c] + LO_W'(r_alo[c]);
                        end
                        r_i <= r_i + CNT_W'(1);
                        if (emit_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EMPTY: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_px        <= '0;
                        r_py        <= '0;
                        r_pz        <= '0;
                        r_idx       <= '0;
                        r_empty     <= 1'b1;
                        r_oclip     <= 1'b0;
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_point_x      = r_px;
    assign o_point_y      = r_py;
    assign o_point_z      = r_pz;
    assign o_sample_index = r_idx;
    assign o_empty_res    = r_empty;
    assign o_clipped      = r_oclip;
    assign o_last         = r_last;

    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_empty_res) |-> (o_last && !o_clipped && (o_sample_index == '0)))
        else $error("empty result must be a single final result");

    a_busy_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid))
        else $error("block went busy without a request");

    a_points_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last) |=> o_out_valid)
        else $error("gap inside a run of sample points");

endmodule
